// File: hdl/dxt1_pkg.sv
// dxt1_pkg: shared types, constants and channel arithmetic for the dxt1 block decoder
// no dependencies; used by dxt1_palette, dxt1_row_mux and dxt1_block_decoder
`timescale 1ns / 1ps

package dxt1_pkg;

  localparam int unsigned ColorWidth  = 24;
  localparam int unsigned ChanWidth   = 8;
  localparam int unsigned EndWidth    = 16;
  localparam int unsigned IndexWidth  = 32;
  localparam int unsigned RowBits     = 8;
  localparam int unsigned NumCols     = 4;

  // reset value of the transparent color register
  localparam logic [ColorWidth-1:0] TransparentReset = 24'h00ff00;

  // reciprocal of three, scaled by 2^11, exact for sums below 1024
  localparam logic [9:0] RecipThree = 10'd683;

  // last row of a block
  localparam logic [1:0] LastRow = 2'd3;

  typedef logic [ColorWidth-1:0] rgb_t;
  typedef logic [ChanWidth-1:0]  chan_t;
  typedef logic [1:0]            pal_sel_t;

  // four palette entries
  typedef rgb_t palette_t [4];

  // four colors of one pixel row
  typedef rgb_t row_pixels_t [NumCols];

  // widen rgb565 by plain shifts, low channel bits zero
  function automatic rgb_t expand565(input logic [EndWidth-1:0] v);
    expand565 = {v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
  endfunction

  // floor((2a + b) / 3) on one channel
  function automatic chan_t third_chan(input chan_t a, input chan_t b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = {1'b0, a, 1'b0} + {2'b00, b};
    prod = sum * RecipThree;
    third_chan = prod[18:11];
  endfunction

  // floor((a + b) / 2) on one channel
  function automatic chan_t half_chan(input chan_t a, input chan_t b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    half_chan = sum[8:1];
  endfunction

  function automatic rgb_t blend_third(input rgb_t a, input rgb_t b);
    blend_third = {third_chan(a[23:16], b[23:16]),
                   third_chan(a[15:8], b[15:8]),
                   third_chan(a[7:0], b[7:0])};
  endfunction

  function automatic rgb_t blend_half(input rgb_t a, input rgb_t b);
    blend_half = {half_chan(a[23:16], b[23:16]),
                  half_chan(a[15:8], b[15:8]),
                  half_chan(a[7:0], b[7:0])};
  endfunction

endpackage

// File: hdl/dxt1_block_decoder.sv
// dxt1_block_decoder: top level of the dxt1 block decoder
// depends on dxt1_pkg, dxt1_palette and dxt1_row_mux
`timescale 1ns / 1ps

// Usage
// - command channel: a block (two rgb565 endpoints, 32 index bits) is taken at a
//   rising edge with start_i high and busy_o low; it is held in the input register
// - result channel: one pixel row per cycle on row_number_o, pixel_0_o..pixel_3_o
//   and last_row_o, marked by out_valid_o for exactly one cycle; no back-pressure
// - row order: row 0 is captured in the result register at the edge after the
//   accepting edge and is on the ports in the cycle after that; rows 1..3 follow
//   in consecutive cycles, last_row_o marks row 3
// - back to back: the single result register gives one row per cycle; busy_o drops
//   while row 3 is being formed, so the next block enters with no gap in the row
//   stream
// - config: cfg_valid_i/cfg_data_i write the transparent color, cfg_ready_o is
//   always high; write it only while no block is in flight
// - reset: rst_ni low clears the input and result valid flags and sets the
//   transparent color to 0x00ff00

module dxt1_block_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [dxt1_pkg::EndWidth-1:0]       color_0_i,
  input  logic [dxt1_pkg::EndWidth-1:0]       color_1_i,
  input  logic [dxt1_pkg::IndexWidth-1:0]     index_bits_i,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dxt1_pkg::ColorWidth-1:0]     cfg_data_i,
  // result channel
  output logic                                out_valid_o,
  output logic [1:0]                          row_number_o,
  output logic [dxt1_pkg::ColorWidth-1:0]     pixel_0_o,
  output logic [dxt1_pkg::ColorWidth-1:0]     pixel_1_o,
  output logic [dxt1_pkg::ColorWidth-1:0]     pixel_2_o,
  output logic [dxt1_pkg::ColorWidth-1:0]     pixel_3_o,
  output logic                                last_row_o
);

  logic                                item_valid_q, item_valid_d;
  logic [1:0]                          row_q, row_d;
  logic [dxt1_pkg::EndWidth-1:0]       color_0_q;
  logic [dxt1_pkg::EndWidth-1:0]       color_1_q;
  logic [dxt1_pkg::IndexWidth-1:0]     index_q;
  dxt1_pkg::rgb_t                      transparent_q;

  logic                                out_valid_q;
  logic [1:0]                          row_number_q;
  dxt1_pkg::row_pixels_t               pixels_q;
  logic                                last_row_q;

  logic                                accept;
  dxt1_pkg::palette_t                  palette;
  dxt1_pkg::row_pixels_t               row_pixels;
  logic [dxt1_pkg::RowBits-1:0]        row_idx;

  // handshakes
  assign busy_o      = item_valid_q && (row_q != dxt1_pkg::LastRow);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // transparent color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transparent_q <= dxt1_pkg::TransparentReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      transparent_q <= cfg_data_i;
    end
  end

  // input register control: hold a block for four rows
  always_comb begin
    item_valid_d = item_valid_q;
    row_d        = row_q;
    if (accept) begin
      item_valid_d = 1'b1;
      row_d        = '0;
    end else if (item_valid_q) begin
      if (row_q == dxt1_pkg::LastRow) begin
        item_valid_d = 1'b0;
      end else begin
        row_d = row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      row_q        <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      row_q        <= row_d;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      color_0_q <= color_0_i;
      color_1_q <= color_1_i;
      index_q   <= index_bits_i;
    end
  end

  // palette and row selection
  dxt1_palette u_palette (
    .color_0_i     (color_0_q),
    .color_1_i     (color_1_q),
    .transparent_i (transparent_q),
    .palette_o     (palette)
  );

  assign row_idx = index_q[{row_q, 3'b000} +: dxt1_pkg::RowBits];

  dxt1_row_mux u_row_mux (
    .palette_i (palette),
    .row_idx_i (row_idx),
    .pixels_o  (row_pixels)
  );

  // result register: valid strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= item_valid_q;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (item_valid_q) begin
      row_number_q <= row_q;
      pixels_q     <= row_pixels;
      last_row_q   <= (row_q == dxt1_pkg::LastRow);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_number_o = row_number_q;
  assign pixel_0_o    = pixels_q[0];
  assign pixel_1_o    = pixels_q[1];
  assign pixel_2_o    = pixels_q[2];
  assign pixel_3_o    = pixels_q[3];
  assign last_row_o   = last_row_q;

endmodule

// File: hdl/dxt1_palette.sv
// dxt1_palette: builds the four-entry palette from the two endpoints
// depends on dxt1_pkg
`timescale 1ns / 1ps

module dxt1_palette (
  input  logic [dxt1_pkg::EndWidth-1:0] color_0_i,
  input  logic [dxt1_pkg::EndWidth-1:0] color_1_i,
  input  dxt1_pkg::rgb_t                transparent_i,
  output dxt1_pkg::palette_t            palette_o
);

  dxt1_pkg::rgb_t end_a;
  dxt1_pkg::rgb_t end_b;

  // expanded endpoints
  assign end_a = dxt1_pkg::expand565(color_0_i);
  assign end_b = dxt1_pkg::expand565(color_1_i);

  // four-color mode when endpoint 0 is greater, else three colors plus transparent
  always_comb begin
    palette_o[0] = end_a;
    palette_o[1] = end_b;
    if (end_a > end_b) begin
      palette_o[2] = dxt1_pkg::blend_third(end_a, end_b);
      palette_o[3] = dxt1_pkg::blend_third(end_b, end_a);
    end else begin
      palette_o[2] = dxt1_pkg::blend_half(end_a, end_b);
      palette_o[3] = transparent_i;
    end
  end

endmodule

// File: hdl/dxt1_row_mux.sv
// dxt1_row_mux: picks the four palette colors of one pixel row
// depends on dxt1_pkg
`timescale 1ns / 1ps

module dxt1_row_mux (
  input  dxt1_pkg::palette_t                palette_i,
  input  logic [dxt1_pkg::RowBits-1:0]      row_idx_i,
  output dxt1_pkg::row_pixels_t             pixels_o
);

  // one 2-bit index per column, lowest pair is the leftmost pixel
  always_comb begin
    for (int c = 0; c < dxt1_pkg::NumCols; c++) begin
      pixels_o[c] = palette_i[row_idx_i[2*c +: 2]];
    end
  end

endmodule

// File: tb/tb_dxt1_block_decoder.sv
// tb_dxt1_block_decoder: self-checking testbench for the dxt1 block decoder
// depends on dxt1_pkg and dxt1_block_decoder; directed block table, then random blocks
// checked row by row against a built-in palette predictor over several transparent colors
`timescale 1ns / 1ps

module tb_dxt1_block_decoder;

  localparam int NumDirected  = 16;
  localparam int NumPhases    = 4;
  localparam int BlocksPerPhase = 24;
  localparam int CycleLimit   = 60000;

  // one expected pixel row
  typedef struct packed {
    logic [1:0]     row;
    dxt1_pkg::rgb_t px0;
    dxt1_pkg::rgb_t px1;
    dxt1_pkg::rgb_t px2;
    dxt1_pkg::rgb_t px3;
    logic           last;
  } row_t;

  // one directed block; flat marks blocks whose every pixel has the same known color
  typedef struct packed {
    logic [15:0]    c0;
    logic [15:0]    c1;
    logic [31:0]    idx;
    logic           flat;
    dxt1_pkg::rgb_t color;
  } block_vec_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  logic [15:0]    color_0_i;
  logic [15:0]    color_1_i;
  logic [31:0]    index_bits_i;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  dxt1_pkg::rgb_t cfg_data_i;
  logic           out_valid_o;
  logic [1:0]     row_number_o;
  dxt1_pkg::rgb_t pixel_0_o;
  dxt1_pkg::rgb_t pixel_1_o;
  dxt1_pkg::rgb_t pixel_2_o;
  dxt1_pkg::rgb_t pixel_3_o;
  logic           last_row_o;

  // typed expectation that travels with the block being offered
  logic           flat_check;
  dxt1_pkg::rgb_t flat_color;

  row_t           expected_rows [$];
  dxt1_pkg::rgb_t transparent_model;
  int             mismatch_count;
  int             cycle_count;
  block_vec_t     directed_blocks [NumDirected];

  dxt1_block_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .color_0_i    (color_0_i),
    .color_1_i    (color_1_i),
    .index_bits_i (index_bits_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .row_number_o (row_number_o),
    .pixel_0_o    (pixel_0_o),
    .pixel_1_o    (pixel_1_o),
    .pixel_2_o    (pixel_2_o),
    .pixel_3_o    (pixel_3_o),
    .last_row_o   (last_row_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // rgb565 to 24-bit color, low channel bits left at zero
  function automatic dxt1_pkg::rgb_t widen_565(input logic [15:0] v);
    dxt1_pkg::rgb_t c;
    c = '0;
    c[23:19] = v[15:11];
    c[15:10] = v[10:5];
    c[7:3]   = v[4:0];
    return c;
  endfunction

  // floor((2a + b) / 3) on each channel
  function automatic dxt1_pkg::rgb_t mix_two_thirds(input dxt1_pkg::rgb_t a,
                                                    input dxt1_pkg::rgb_t b);
    dxt1_pkg::rgb_t c;
    int   s;
    for (int k = 0; k < 3; k++) begin
      s = 2 * int'(a[8*k +: 8]) + int'(b[8*k +: 8]);
      c[8*k +: 8] = 8'(s / 3);
    end
    return c;
  endfunction

  // floor((a + b) / 2) on each channel
  function automatic dxt1_pkg::rgb_t mix_half(input dxt1_pkg::rgb_t a,
                                              input dxt1_pkg::rgb_t b);
    dxt1_pkg::rgb_t c;
    int   s;
    for (int k = 0; k < 3; k++) begin
      s = int'(a[8*k +: 8]) + int'(b[8*k +: 8]);
      c[8*k +: 8] = 8'(s / 2);
    end
    return c;
  endfunction

  // queue the four pixel rows that one block decodes to
  task automatic predict_block_rows(input logic [15:0] c0, input logic [15:0] c1,
                                    input logic [31:0] idx);
    dxt1_pkg::rgb_t colors [4];
    dxt1_pkg::rgb_t px [4];
    row_t r;
    colors[0] = widen_565(c0);
    colors[1] = widen_565(c1);
    if (colors[0] > colors[1]) begin
      colors[2] = mix_two_thirds(colors[0], colors[1]);
      colors[3] = mix_two_thirds(colors[1], colors[0]);
    end else begin
      colors[2] = mix_half(colors[0], colors[1]);
      colors[3] = transparent_model;
    end
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        px[col] = colors[idx[2*(4*row + col) +: 2]];
      end
      r.row  = 2'(row);
      r.px0  = px[0];
      r.px1  = px[1];
      r.px2  = px[2];
      r.px3  = px[3];
      r.last = (r.row == dxt1_pkg::LastRow);
      expected_rows.push_back(r);
    end
  endtask

  // four rows of one known color
  task automatic queue_flat_rows(input dxt1_pkg::rgb_t color);
    row_t r;
    for (int row = 0; row < 4; row++) begin
      r = '{row: 2'(row), px0: color, px1: color, px2: color, px3: color,
            last: (2'(row) == dxt1_pkg::LastRow)};
      expected_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h (cycle %0d)", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  // result checker, register mirror and block acceptance, all at the rising edge
  always @(posedge clk_i) begin
    row_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d rows still expected", expected_rows.size());
      $display("FAILURE");
      $finish;
    end else begin
      // compare the row on the result ports with the oldest expectation
      if (rst_ni && out_valid_o) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected row", 32'(row_number_o), 32'h0);
        end else begin
          want = expected_rows.pop_front();
          if (row_number_o !== want.row)
            report_mismatch("row_number", 32'(row_number_o), 32'(want.row));
          if (pixel_0_o !== want.px0) report_mismatch("pixel_0", 32'(pixel_0_o), 32'(want.px0));
          if (pixel_1_o !== want.px1) report_mismatch("pixel_1", 32'(pixel_1_o), 32'(want.px1));
          if (pixel_2_o !== want.px2) report_mismatch("pixel_2", 32'(pixel_2_o), 32'(want.px2));
          if (pixel_3_o !== want.px3) report_mismatch("pixel_3", 32'(pixel_3_o), 32'(want.px3));
          if (last_row_o !== want.last)
            report_mismatch("last_row", 32'(last_row_o), 32'(want.last));
        end
      end
      // register write transaction
      if (rst_ni && cfg_valid_i && cfg_ready_o) begin
        transparent_model = cfg_data_i;
      end
      // block accepted at this edge
      if (rst_ni && start_i && !busy_o) begin
        if (flat_check) begin
          queue_flat_rows(flat_color);
        end else begin
          predict_block_rows(color_0_i, color_1_i, index_bits_i);
        end
      end
    end
  end

  // offer one block and hold it until the decoder takes it
  task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
                            input logic [31:0] idx, input logic flat,
                            input dxt1_pkg::rgb_t color);
    @(negedge clk_i);
    start_i      = 1'b1;
    color_0_i    = c0;
    color_1_i    = c1;
    index_bits_i = idx;
    flat_check   = flat;
    flat_color   = color;
    do @(posedge clk_i); while (busy_o);
  endtask

  // sender idle cycles with noise on the data ports
  task automatic idle_gap(input int cycles);
    for (int n = 0; n < cycles; n++) begin
      @(negedge clk_i);
      start_i      = 1'b0;
      flat_check   = 1'b0;
      color_0_i    = 16'($urandom);
      color_1_i    = 16'($urandom);
      index_bits_i = $urandom;
    end
  endtask

  // stop offering and let every outstanding row come out
  task automatic wait_drained();
    @(negedge clk_i);
    start_i    = 1'b0;
    flat_check = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_transparent(input dxt1_pkg::rgb_t value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = 24'($urandom);
  endtask

  // random block: mostly random endpoints, some equal, some just apart, some in 3-color order
  task automatic pick_random_block(output logic [15:0] c0, output logic [15:0] c1,
                                   output logic [31:0] idx);
    int kind;
    logic [15:0] tmp;
    kind = $urandom_range(0, 9);
    c0 = 16'($urandom);
    c1 = 16'($urandom);
    if (kind inside {[6:7]}) begin
      c1 = c0;
    end else if (kind == 8) begin
      c1 = c0 - 16'd1;
    end else if (kind == 9 && c0 > c1) begin
      tmp = c0;
      c0  = c1;
      c1  = tmp;
    end
    if ($urandom_range(0, 7) == 0) begin
      idx = {16{2'($urandom)}};
    end else begin
      idx = $urandom;
    end
  endtask

  // stimulus
  initial begin
    logic [15:0]    c0;
    logic [15:0]    c1;
    logic [31:0]    idx;
    dxt1_pkg::rgb_t tcolor;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    color_0_i      = '0;
    color_1_i      = '0;
    index_bits_i   = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    flat_check     = 1'b0;
    flat_color     = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    transparent_model = dxt1_pkg::TransparentReset;

    // directed blocks; color is the known pixel color where flat is set
    directed_blocks = '{
      '{c0: 16'h0000, c1: 16'h0000, idx: 32'h00000000, flat: 1'b1, color: 24'h000000},
      '{c0: 16'h0000, c1: 16'h0000, idx: 32'hffffffff, flat: 1'b1, color: 24'h00ff00},
      '{c0: 16'hffff, c1: 16'hffff, idx: 32'h00000000, flat: 1'b1, color: 24'hf8fcf8},
      '{c0: 16'hffff, c1: 16'hffff, idx: 32'hffffffff, flat: 1'b1, color: 24'h00ff00},
      '{c0: 16'hffff, c1: 16'h0000, idx: 32'h55555555, flat: 1'b1, color: 24'h000000},
      '{c0: 16'hffff, c1: 16'h0000, idx: 32'haaaaaaaa, flat: 1'b1, color: 24'ha5a8a5},
      '{c0: 16'hffff, c1: 16'h0000, idx: 32'hffffffff, flat: 1'b1, color: 24'h525452},
      '{c0: 16'h0000, c1: 16'hffff, idx: 32'haaaaaaaa, flat: 1'b1, color: 24'h7c7e7c},
      '{c0: 16'h0000, c1: 16'hffff, idx: 32'hffffffff, flat: 1'b1, color: 24'h00ff00},
      '{c0: 16'h0001, c1: 16'h0000, idx: 32'he4e4e4e4, flat: 1'b0, color: 24'h000000},
      '{c0: 16'h0000, c1: 16'h0001, idx: 32'h1b1b1b1b, flat: 1'b0, color: 24'h000000},
      '{c0: 16'hf800, c1: 16'h07e0, idx: 32'he4e4e4e4, flat: 1'b0, color: 24'h000000},
      '{c0: 16'h001f, c1: 16'hf800, idx: 32'h4e4e4e4e, flat: 1'b0, color: 24'h000000},
      '{c0: 16'h1234, c1: 16'habcd, idx: 32'h12345678, flat: 1'b0, color: 24'h000000},
      '{c0: 16'hffff, c1: 16'hfffe, idx: 32'hffffffff, flat: 1'b0, color: 24'h000000},
      '{c0: 16'h7bef, c1: 16'h8410, idx: 32'h000000ff, flat: 1'b0, color: 24'h000000}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part under the reset transparent color, back to back first
    for (int i = 0; i < NumDirected; i++) begin
      send_block(directed_blocks[i].c0, directed_blocks[i].c1, directed_blocks[i].idx,
                 directed_blocks[i].flat, directed_blocks[i].color);
      idle_gap(i < 6 ? 0 : $urandom_range(0, 16));
    end
    wait_drained();

    // random phases, each under its own transparent color
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: tcolor = 24'hffffff;
        1: tcolor = 24'h000000;
        default: tcolor = 24'($urandom);
      endcase
      write_transparent(tcolor);
      for (int n = 0; n < BlocksPerPhase; n++) begin
        pick_random_block(c0, c1, idx);
        send_block(c0, c1, idx, 1'b0, '0);
        idle_gap((n % 12) < 5 ? 0 : $urandom_range(0, 16));
      end
      wait_drained();
    end

    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
